@@ hdl/kftb_pkg.sv @@
`default_nettype none

package kftb_pkg;

	localparam int SLOTS_DEF      = 32;
	localparam int COUNT_BITS_DEF = 24;

	localparam int CAP_W    = 24;
	localparam int FPS_W    = 10;
	localparam int KEY_W    = 32;
	localparam int AMOUNT_W = 24;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 5;
	localparam int PROD_W   = AMOUNT_W + FPS_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CAP_W-1:0] CAP_RST = 24'hFFFFFF;
	localparam logic [FPS_W-1:0] FPS_RST = 10'd60;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK    = 3'd0,
		ACT_ADD_TCK = 3'd1,
		ACT_ADD_SEC = 3'd2,
		ACT_REMOVE  = 3'd3,
		ACT_CHECK   = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD_KEY   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_CAP = 1'd0,
		REG_FPS      = 1'd1
	} cfg_reg_t;

	// command token handed from cell to cell
	typedef struct packed {
		logic              valid;
		action_t           action;
		logic              done;
		status_t           status;
		logic              fired;
		logic [SLOT_W-1:0] slot;
	} token_ctl_t;

endpackage

`default_nettype wire

@@ hdl/kftb_cell.sv @@
`default_nettype none

module kftb_cell #(
	parameter int COUNT_BITS = kftb_pkg::COUNT_BITS_DEF,
	parameter int INDEX      = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [kftb_pkg::CAP_W-1:0]    tick_cap,
	input  wire kftb_pkg::token_ctl_t          ctl_in,
	input  wire logic [kftb_pkg::KEY_W-1:0]    key_in,
	input  wire logic [COUNT_BITS-1:0]         lim_in,
	output kftb_pkg::token_ctl_t               ctl_out,
	output logic [kftb_pkg::KEY_W-1:0]         key_out,
	output logic [COUNT_BITS-1:0]              lim_out
);

	logic                         used_q;
	logic [kftb_pkg::KEY_W-1:0]   key_q;
	logic [COUNT_BITS-1:0]        count_q;
	logic [COUNT_BITS-1:0]        limit_q;
	logic                         pend_q;
	kftb_pkg::token_ctl_t         ctl_q;
	logic [kftb_pkg::KEY_W-1:0]   key_fwd_q;
	logic [COUNT_BITS-1:0]        lim_fwd_q;

	logic is_add, is_keyed, is_tick, live;
	logic hit_free, hit_key, at_cap, fire;
	kftb_pkg::token_ctl_t ctl_nxt;

	always_comb begin
		is_add   = (ctl_in.action == kftb_pkg::ACT_ADD_TCK) ||
		           (ctl_in.action == kftb_pkg::ACT_ADD_SEC);
		is_keyed = (ctl_in.action == kftb_pkg::ACT_REMOVE) ||
		           (ctl_in.action == kftb_pkg::ACT_CHECK);
		is_tick  = ctl_in.valid && (ctl_in.action == kftb_pkg::ACT_TICK);
		live     = ctl_in.valid && !ctl_in.done;
		hit_free = live && is_add && !used_q;
		hit_key  = live && is_keyed && used_q && (key_q == key_in);
		at_cap   = {{(33-COUNT_BITS){1'b0}}, count_q} >=
		           {{(33-kftb_pkg::CAP_W){1'b0}}, tick_cap};
		fire     = hit_key && (ctl_in.action == kftb_pkg::ACT_CHECK) &&
		           (count_q == limit_q);
		ctl_nxt  = ctl_in;
		if (hit_free || hit_key) begin
			ctl_nxt.done   = 1'b1;
			ctl_nxt.status = kftb_pkg::ST_OK;
			ctl_nxt.slot   = kftb_pkg::SLOT_W'(INDEX);
			ctl_nxt.fired  = fire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			ctl_q  <= '0;
		end else begin
			ctl_q <= ctl_nxt;
			if (hit_free)
				used_q <= 1'b1;
			else if (hit_key && (ctl_in.action == kftb_pkg::ACT_REMOVE))
				used_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		key_fwd_q <= key_in;
		lim_fwd_q <= lim_in;
		if (hit_free) begin
			key_q   <= key_in;
			limit_q <= lim_in;
			count_q <= lim_in;
			pend_q  <= 1'b0;
		end else if (fire) begin
			pend_q <= 1'b1;
		end else if (is_tick && used_q) begin
			if (at_cap || pend_q) begin
				count_q <= '0;
				pend_q  <= 1'b0;
			end else begin
				count_q <= count_q + COUNT_BITS'(1);
			end
		end
	end

	assign ctl_out = ctl_q;
	assign key_out = key_fwd_q;
	assign lim_out = lim_fwd_q;

endmodule

`default_nettype wire

@@ hdl/keyed_frame_timer_bank.sv @@
// One command at a time: the command token walks the slot chain one cell per cycle,
// and the next command is taken once the result of the last one moves into the
// output register.
// A finished result may wait on the output while the next command is taken.
// Reset: all slots free, tick_cap 16777215, frames_per_second 60.
`default_nettype none

module keyed_frame_timer_bank #(
	parameter int SLOTS      = kftb_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = kftb_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command stream
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [63:0]                       s_axis_tdata,  // action[2:0] key[34:3] amount[58:35]
	// result stream
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [7:0]                             m_axis_tdata,  // status[1:0] fired[2] slot[7:3]
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [kftb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [kftb_pkg::CAP_W-1:0]        cfg_data
);

	localparam logic [kftb_pkg::PROD_W-1:0] COUNT_MAX =
		kftb_pkg::PROD_W'((64'd1 << COUNT_BITS) - 64'd1);

	// configuration registers
	logic [kftb_pkg::CAP_W-1:0] tick_cap_q;
	logic [kftb_pkg::FPS_W-1:0] fps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cap_q <= kftb_pkg::CAP_RST;
			fps_q      <= kftb_pkg::FPS_RST;
		end else if (cfg_we) begin
			unique case (kftb_pkg::cfg_reg_t'(cfg_index))
				kftb_pkg::REG_TICK_CAP: tick_cap_q <= cfg_data;
				kftb_pkg::REG_FPS:      fps_q      <= cfg_data[kftb_pkg::FPS_W-1:0];
				default: ;
			endcase
		end
	end

	// one command in flight: hold off new transfers until its result is queued
	logic busy_q;
	logic in_xfer;
	assign s_axis_tready = !busy_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// stage 1: latch the command, form seconds * frames_per_second
	logic                              valid_s1;
	kftb_pkg::action_t                 action_s1;
	logic [kftb_pkg::KEY_W-1:0]        key_s1;
	logic [kftb_pkg::AMOUNT_W-1:0]     amount_s1;
	logic [kftb_pkg::PROD_W-1:0]       prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_xfer;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1 <= kftb_pkg::action_t'(s_axis_tdata[2:0]);
			key_s1    <= s_axis_tdata[34:3];
			amount_s1 <= s_axis_tdata[58:35];
			prod_s1   <= kftb_pkg::PROD_W'(s_axis_tdata[58:35]) *
			             kftb_pkg::PROD_W'(fps_q);
		end
	end

	// stage 2: saturate the limit and preset the outcome for when no slot takes it
	kftb_pkg::token_ctl_t            ctl_nxt_s2, ctl_s2;
	logic [kftb_pkg::KEY_W-1:0]      key_s2;
	logic [COUNT_BITS-1:0]           lim_s2;
	logic [kftb_pkg::PROD_W-1:0]     lim_full;

	always_comb begin
		lim_full = (action_s1 == kftb_pkg::ACT_ADD_SEC) ? prod_s1 :
		           kftb_pkg::PROD_W'(amount_s1);
		ctl_nxt_s2        = '0;
		ctl_nxt_s2.valid  = valid_s1;
		ctl_nxt_s2.action = action_s1;
		case (action_s1) inside
			kftb_pkg::ACT_ADD_TCK, kftb_pkg::ACT_ADD_SEC: begin
				if (key_s1 == '0) begin
					ctl_nxt_s2.done   = 1'b1;
					ctl_nxt_s2.status = kftb_pkg::ST_BAD_KEY;
				end else begin
					ctl_nxt_s2.status = kftb_pkg::ST_FULL;
				end
			end
			kftb_pkg::ACT_REMOVE, kftb_pkg::ACT_CHECK:
				ctl_nxt_s2.status = kftb_pkg::ST_NOT_FOUND;
			default: begin
				// tick still walks the chain so every slot advances
				ctl_nxt_s2.done   = 1'b1;
				ctl_nxt_s2.status = kftb_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s2 <= '0;
		else
			ctl_s2 <= ctl_nxt_s2;
	end

	always_ff @(posedge clk) begin
		key_s2 <= key_s1;
		lim_s2 <= (lim_full > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] :
		          lim_full[COUNT_BITS-1:0];
	end

	// slot chain: cell i holds slot i, lowest slot sees the token first
	kftb_pkg::token_ctl_t            ctl_c [SLOTS+1];
	logic [kftb_pkg::KEY_W-1:0]      key_c [SLOTS+1];
	logic [COUNT_BITS-1:0]           lim_c [SLOTS+1];

	assign ctl_c[0] = ctl_s2;
	assign key_c[0] = key_s2;
	assign lim_c[0] = lim_s2;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		kftb_cell #(
			.COUNT_BITS (COUNT_BITS),
			.INDEX      (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tick_cap (tick_cap_q),
			.ctl_in   (ctl_c[i]),
			.key_in   (key_c[i]),
			.lim_in   (lim_c[i]),
			.ctl_out  (ctl_c[i+1]),
			.key_out  (key_c[i+1]),
			.lim_out  (lim_c[i+1])
		);
	end

	// result holding stage, then the output register
	kftb_pkg::token_ctl_t tail;
	logic                 res_valid_q;
	kftb_pkg::status_t    res_status_q;
	logic                 res_fired_q;
	logic [kftb_pkg::SLOT_W-1:0] res_slot_q;
	logic                 out_valid_q;
	kftb_pkg::status_t    out_status_q;
	logic                 out_fired_q;
	logic [kftb_pkg::SLOT_W-1:0] out_slot_q;
	logic                 out_load;

	assign tail     = ctl_c[SLOTS];
	assign out_load = res_valid_q && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer)
				busy_q <= 1'b1;
			else if (out_load)
				busy_q <= 1'b0;
			if (tail.valid)
				res_valid_q <= 1'b1;
			else if (out_load)
				res_valid_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			res_status_q <= tail.status;
			res_fired_q  <= tail.fired;
			res_slot_q   <= tail.slot;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_fired_q  <= res_fired_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_slot_q, out_fired_q, out_status_q};

endmodule

`default_nettype wire

@@ tb/keyed_frame_timer_bank_test.sv @@
`timescale 1ns / 100ps

module keyed_frame_timer_bank_test;

	import kftb_pkg::*;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int COUNT_BITS  = COUNT_BITS_DEF;
	localparam int LATENCY     = SLOTS + 4;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// action codes the block treats as no-ops
	localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [AMOUNT_W-1:0] amount;
		logic [KEY_W-1:0]    key;
		logic [ACTION_W-1:0] action;
	} command_t;

	typedef struct packed {
		status_t           status;
		logic              fired;
		logic [SLOT_W-1:0] slot;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [63:0]          s_axis_tdata = '0;  // action[2:0] key[34:3] amount[58:35]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;       // status[1:0] fired[2] slot[7:3]
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CAP_W-1:0]     cfg_data = '0;

	keyed_frame_timer_bank DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Commands waiting to be offered, and outcomes predicted for accepted commands,
	// oldest first.
	command_t queued_commands[$];
	outcome_t due_outcomes[$];

	// Shadow of the timer bank and its registers.
	logic                  bank_used  [SLOTS];
	logic [KEY_W-1:0]      bank_key   [SLOTS];
	logic [COUNT_BITS-1:0] bank_count [SLOTS];
	logic [COUNT_BITS-1:0] bank_limit [SLOTS];
	logic                  bank_rearm [SLOTS];
	logic [CAP_W-1:0]      tick_cap   = CAP_RST;
	logic [FPS_W-1:0]      frame_rate = FPS_RST;

	logic [KEY_W-1:0] key_pool[6];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	outcome_t seen, wanted;

	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the shadow bank by one command and return the outcome it must give.
	function automatic outcome_t predict_command(command_t c);
		outcome_t r;
		int hit;
		int free_slot;
		longint unsigned lim;
		r.status = ST_OK;
		r.fired = 1'b0;
		r.slot = '0;
		hit = -1;
		free_slot = -1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (bank_used[i] && bank_key[i] == c.key)
				hit = i;
			if (!bank_used[i])
				free_slot = i;
		end
		case (c.action)
			ACT_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (bank_used[i]) begin
						if (bank_count[i] >= tick_cap || bank_rearm[i]) begin
							bank_count[i] = '0;
							bank_rearm[i] = 1'b0;
						end else begin
							bank_count[i] = bank_count[i] + 1'b1;
						end
					end
				end
			end
			ACT_ADD_TCK, ACT_ADD_SEC: begin
				// zero key is refused before the bank-full test
				if (c.key == '0) begin
					r.status = ST_BAD_KEY;
				end else if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					lim = 64'(c.amount);
					if (c.action == ACT_ADD_SEC)
						lim = 64'(c.amount) * 64'(frame_rate);
					if (lim > 64'(COUNT_MAX))
						lim = 64'(COUNT_MAX);
					bank_used[free_slot]  = 1'b1;
					bank_key[free_slot]   = c.key;
					bank_limit[free_slot] = COUNT_BITS'(lim);
					bank_count[free_slot] = COUNT_BITS'(lim);
					bank_rearm[free_slot] = 1'b0;
					r.slot = SLOT_W'(free_slot);
				end
			end
			ACT_REMOVE: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					bank_used[hit] = 1'b0;
					r.slot = SLOT_W'(hit);
				end
			end
			ACT_CHECK: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.slot = SLOT_W'(hit);
					if (bank_count[hit] == bank_limit[hit]) begin
						bank_rearm[hit] = 1'b1;
						r.fired = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void queue_cmd(logic [ACTION_W-1:0] a, logic [KEY_W-1:0] k,
			logic [AMOUNT_W-1:0] amt);
		command_t c;
		c.action = a;
		c.key = k;
		c.amount = amt;
		queued_commands.push_back(c);
	endfunction

	// Mostly well-formed traffic on a small key pool so that duplicates, matches,
	// firing checks and a full bank all occur; a few percent is noise.
	task automatic random_commands(int n, int amt_max, int add_pct);
		int roll;
		logic [KEY_W-1:0] k;
		logic [AMOUNT_W-1:0] amt;
		logic [ACTION_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(5)];
			amt = ($urandom_range(9) == 0) ? AMOUNT_W'($urandom()) :
				AMOUNT_W'($urandom_range(amt_max));
			roll = $urandom_range(99);
			if (roll < add_pct) begin
				a = $urandom_range(1) ? ACT_ADD_SEC : ACT_ADD_TCK;
				if ($urandom_range(29) == 0)
					k = '0;
			end else if (roll < add_pct + 15) begin
				a = ACT_REMOVE;
			end else if (roll < add_pct + 45) begin
				a = ACT_CHECK;
			end else if (roll < 96) begin
				a = ACT_TICK;
			end else begin
				a = ACTION_W'($urandom_range(7));
				k = $urandom();
				amt = AMOUNT_W'($urandom());
			end
			queue_cmd(a, k, amt);
		end
	endtask

	// Hold until every command is taken and every outcome has returned, then let
	// the pipeline settle.
	task automatic wait_drained();
		while (queued_commands.size() != 0 || s_axis_tvalid || due_outcomes.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TICK_CAP: tick_cap = value;
			REG_FPS:      frame_rate = value[FPS_W-1:0];
			default: begin
			end
		endcase
	endtask

	// Reprogram both registers on an idle block, set the idling mix, then queue
	// the phase's random traffic.
	task automatic run_phase(logic [CAP_W-1:0] cap, logic [FPS_W-1:0] fps, int tx_pct,
			int rx_pct, int n, int amt_max, int add_pct);
		wait_drained();
		write_reg(REG_TICK_CAP, cap);
		write_reg(REG_FPS, CAP_W'(fps));
		@(negedge clk);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		random_commands(n, amt_max, add_pct);
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			bank_used[i]  = 1'b0;
			bank_key[i]   = '0;
			bank_count[i] = '0;
			bank_limit[i] = '0;
			bank_rearm[i] = 1'b0;
		end
		key_pool[0] = '1;
		key_pool[1] = 32'h0000_0001;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = $urandom() | 32'h1;
		key_pool[4] = $urandom() | 32'h2;
		key_pool[5] = $urandom() | 32'h4;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		tx_idle_pct = 26;
		rx_idle_pct = 49;

		// Directed opening on the reset settings: empty bank, bad keys, saturation,
		// duplicates, firing and re-arming, and the undefined actions.
		queue_cmd(ACT_TICK, '0, '0);
		queue_cmd(ACT_CHECK, 32'h5, '0);
		queue_cmd(ACT_REMOVE, 32'h5, '0);
		queue_cmd(ACT_ADD_TCK, '0, '1);
		queue_cmd(ACT_ADD_SEC, '0, '1);
		queue_cmd(ACT_ADD_TCK, '1, '1);
		queue_cmd(ACT_ADD_SEC, 32'h1, '1);
		queue_cmd(ACT_ADD_SEC, 32'h2, 24'd3);
		queue_cmd(ACT_ADD_TCK, '1, '0);
		queue_cmd(ACT_CHECK, '1, '0);
		queue_cmd(ACT_CHECK, 32'h1, '0);
		queue_cmd(ACT_TICK, '1, '1);
		queue_cmd(ACT_CHECK, '1, '0);
		queue_cmd(ACT_REMOVE, '1, '0);
		queue_cmd(ACT_CHECK, '1, '0);
		for (logic [3:0] a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			queue_cmd(a[ACTION_W-1:0], $urandom(), AMOUNT_W'($urandom()));
		queue_cmd(ACT_ADD_TCK, 32'h3, 24'd2);
		queue_cmd(ACT_TICK, '0, '0);
		queue_cmd(ACT_TICK, '0, '0);
		queue_cmd(ACT_CHECK, 32'h3, '0);
		queue_cmd(ACT_REMOVE, 32'h2, '0);
		random_commands(300, 6, 35);

		run_phase(24'd3, 10'd1, 26, 49, 250, 4, 35);
		run_phase(24'd0, 10'd1023, 49, 26, 200, 3, 25);
		// zero frame rate makes every seconds-form limit zero
		run_phase('1, 10'd0, 49, 26, 250, 8, 40);
		run_phase(CAP_W'($urandom_range(40, 2)), FPS_W'($urandom_range(1023, 1)), 0, 0,
			380, 10, 30);

		wait_drained();
		if (mismatches == 0)
			$display("keyed_frame_timer_bank_test passed");
		else
			$display("keyed_frame_timer_bank_test failed");
		$finish;
	end

	// Command driver: predict on each transfer, hold tvalid until taken, then
	// offer the next command or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				due_outcomes.push_back(predict_command(queued_commands.pop_front()));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (queued_commands.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'b0, queued_commands[0].amount, queued_commands[0].key,
						queued_commands[0].action};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest prediction and
	// stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.status = status_t'(m_axis_tdata[1:0]);
				seen.fired = m_axis_tdata[2];
				seen.slot = m_axis_tdata[7:3];
				if (due_outcomes.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: status %0d fired %0d slot %0d",
							seen.status, seen.fired, seen.slot);
					mismatches = mismatches + 1;
				end else begin
					wanted = due_outcomes.pop_front();
					if (seen.status != wanted.status || seen.fired != wanted.fired ||
							seen.slot != wanted.slot) begin
						if (mismatches < 10)
							$display("mismatch: status %0d/%0d fired %0d/%0d slot %0d/%0d",
								seen.status, wanted.status, seen.fired, wanted.fired,
								seen.slot, wanted.slot);
						mismatches = mismatches + 1;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Drop the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keyed_frame_timer_bank_test failed");
			$finish;
		end
	end

endmodule
